// ===== rtl/core/bdf_pkg.sv =====
package bdf_pkg;

  // Field and datapath widths.
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned FADE_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MIN_W   = 11;
  localparam int unsigned RAMP_W  = 7;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned MUL_W   = 8;
  localparam int unsigned ROOT_W  = DIV_W / 2;
  localparam int unsigned CNT_W   = 5;

  // Iteration counts of the serial units.
  localparam logic [CNT_W-1:0] MUL_ITERS       = 5'd8;
  localparam logic [CNT_W-1:0] SQRT_ITERS      = 5'd8;
  localparam logic [CNT_W-1:0] DIV_ITERS_RAMP  = 5'd16;
  localparam logic [CNT_W-1:0] DIV_ITERS_STEP  = 5'd8;

  // Timing constants.
  localparam logic [TIME_W-1:0] FRESH_LIMIT_MS = 32'd3000;
  localparam logic [TIME_W-1:0] STEP_PERIOD_MS = 32'd20;

  // Local clock, in hours and in minutes after midnight.
  localparam logic [5:0]       TZ_SHIFT_UP   = 6'd18;
  localparam logic [5:0]       HOURS_PER_DAY = 6'd24;
  localparam logic [MIN_W-1:0] DAWN_START    = 11'd300;
  localparam logic [MIN_W-1:0] DAY_START     = 11'd420;
  localparam logic [MIN_W-1:0] DAY_END       = 11'd1080;
  localparam logic [MIN_W-1:0] DUSK_END      = 11'd1200;
  localparam logic [DIV_W-1:0] RAMP_MINUTES  = 16'd120;

  // Reset values.
  localparam logic [DUTY_W-1:0] DAY_LEVEL_RST   = 8'd255;
  localparam logic [DUTY_W-1:0] NIGHT_LEVEL_RST = 8'd0;
  localparam logic [FADE_W-1:0] FADE_TIME_RST   = 16'd800;
  localparam logic [DUTY_W-1:0] DUTY_RST        = 8'd255;

  typedef enum logic [1:0] {
    CFG_DAY_LEVEL   = 2'd0,
    CFG_NIGHT_LEVEL = 2'd1,
    CFG_FADE_TIME   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_DAY   = 2'd0,
    MODE_NIGHT = 2'd1,
    MODE_AUTO  = 2'd2
  } mode_e;

endpackage

// ===== rtl/core/bdf_serial_mult.sv =====
module bdf_serial_mult import bdf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DIV_W-1:0]       mcand_i,
  input  logic [MUL_W-1:0]       mplier_i,
  output logic [DIV_W+MUL_W-1:0] prod_o,
  output logic                   done_o
);

  logic [DIV_W+MUL_W-1:0] prod_q;
  logic [DIV_W-1:0]       mcand_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [DIV_W:0]         sum_d;

  // Shift-add, one multiplier bit per cycle; the product shifts right under it.
  always_comb begin
    sum_d = {1'b0, prod_q[DIV_W+MUL_W-1:MUL_W]};
    if (prod_q[0]) begin
      sum_d = sum_d + {1'b0, mcand_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_ITERS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      prod_q  <= {{DIV_W{1'b0}}, mplier_i};
    end else if (busy_q) begin
      prod_q <= {sum_d, prod_q[MUL_W-1:1]};
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/bdf_serial_div.sv =====
module bdf_serial_div import bdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] rem_init_i,
  input  logic [DIV_W-1:0] low_i,
  input  logic [DIV_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] iters_i,
  output logic [DIV_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o,
  output logic             done_o
);

  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] low_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W:0]   rsh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The partial remainder
  // always stays below the divisor, so the shifted value fits after a trial.
  always_comb begin
    rsh  = {rem_q, low_q[DIV_W-1]};
    diff = rsh - {1'b0, div_q};
    ge   = (rsh >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      low_q <= low_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : rsh[DIV_W-1:0];
      low_q <= {low_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/bdf_serial_sqrt.sv =====
module bdf_serial_sqrt import bdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  radicand_i,
  output logic [ROOT_W-1:0] root_o,
  output logic              exact_o,
  output logic              done_o
);

  logic [DIV_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] sub;
  logic              ge;

  // Digit-by-digit square root, two radicand bits and one root bit per cycle.
  // The remainder never exceeds twice the partial root.
  always_comb begin
    rem_sh = {rem_q, rad_q[DIV_W-1:DIV_W-2]};
    trial  = {1'b0, root_q, 2'b01};
    sub    = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_ITERS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DIV_W-3:0], 2'b00};
      rem_q  <= ge ? sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o  = root_q;
  assign exact_o = (rem_q == '0);
  assign done_o  = done_q;

endmodule

// ===== rtl/core/backlight_dawn_dusk_fader_unit.sv =====
// An input item is captured, decoded in the prepare step, run through the dawn or
// dusk ramp (two multiplies, a divide and a root) when one is needed and through the
// fade step division when a step is due, then handed to the result register, which
// holds it while stalled. One item at a time: the next input transfer waits until
// the sequencer has handed the previous item on to the result register.
// Reset (asynchronous, active low) restores the register defaults.
module backlight_dawn_dusk_fader_unit import bdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,

  // Input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [1:0]        operation_i,
  input  logic              clock_valid_i,
  input  logic [TIME_W-1:0] clock_stamp_ms_i,
  input  logic [4:0]        utc_hour_i,
  input  logic [5:0]        utc_minute_i,

  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DUTY_W-1:0] duty_o,
  output logic [DUTY_W-1:0] target_duty_o,
  output logic              duty_stepped_o,

  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [FADE_W-1:0] cfg_data_i
);

  // The sequencer walks one item through the shared serial units. Items that
  // need no ramp skip straight from the prepare step to the fade step.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_DIV1 = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_STEP = 9'b001000000,
    S_DIV2 = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DUTY_W-1:0] day_q;
  logic [DUTY_W-1:0] night_q;
  logic [FADE_W-1:0] fade_q;

  // Architectural state.
  logic [DUTY_W-1:0] cur_q;
  logic [DUTY_W-1:0] goal_q;
  logic [TIME_W-1:0] last_q;

  // Captured input item.
  logic [TIME_W-1:0] now_q;
  logic [1:0]        mode_q;
  logic              cvalid_q;
  logic [TIME_W-1:0] stamp_q;
  logic [4:0]        hour_q;
  logic [5:0]        minute_q;

  // Per-item working registers.
  logic [TIME_W-1:0] elapsed_q;
  logic [RAMP_W-1:0] k_q;
  logic              up_q;
  logic              divrem_zero_q;
  logic              step_flag_q;

  // Output register.
  logic              out_valid_q;
  logic [DUTY_W-1:0] out_duty_q;
  logic [DUTY_W-1:0] out_target_q;
  logic              out_stepped_q;

  // Serial unit hookup.
  logic                   mul_start;
  logic [DIV_W-1:0]       mul_mcand;
  logic [MUL_W-1:0]       mul_mplier;
  logic [DIV_W+MUL_W-1:0] mul_prod;
  logic                   mul_done;

  logic             div_start;
  logic [DIV_W-1:0] div_rem_init;
  logic [DIV_W-1:0] div_low;
  logic [DIV_W-1:0] div_divisor;
  logic [CNT_W-1:0] div_iters;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;
  logic             div_done;

  logic              sqrt_start;
  logic [ROOT_W-1:0] sqrt_root;
  logic              sqrt_exact;
  logic              sqrt_done;

  // Prepare-step decode.
  logic              fresh;
  logic [TIME_W-1:0] clock_age;
  logic [5:0]        hour_sum;
  logic [5:0]        hour_m1;
  logic [5:0]        hour_loc;
  logic [MIN_W-1:0]  local_min;
  logic [MIN_W-1:0]  k_full;
  logic [DUTY_W-1:0] level_gap;
  logic              level_up;
  logic [DUTY_W-1:0] goal_direct;
  logic              need_ramp;

  // Fade step.
  logic [FADE_W-1:0]       fade_eff;
  logic [FADE_W-1:0]       span;
  logic [FADE_W+DUTY_W-1:0] scaled;
  logic                    want_step;
  logic [DUTY_W-1:0]       step_amt;
  logic [DUTY_W-1:0]       gap;
  logic [DUTY_W-1:0]       next_duty;
  logic [DUTY_W-1:0]       ramp_goal;
  logic                    out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clock freshness and local time. Local hour is UTC shifted up by 18 and
  // folded into a day; hours beyond 23 still fold, which takes two subtracts.
  always_comb begin
    clock_age = now_q - stamp_q;
    fresh     = cvalid_q && (stamp_q != '0) && (clock_age < FRESH_LIMIT_MS);
    hour_sum  = {1'b0, hour_q} + TZ_SHIFT_UP;
    hour_m1   = (hour_sum >= HOURS_PER_DAY) ? hour_sum - HOURS_PER_DAY : hour_sum;
    hour_loc  = (hour_m1 >= HOURS_PER_DAY) ? hour_m1 - HOURS_PER_DAY : hour_m1;
    local_min = ({hour_loc[4:0], 6'b000000} - {4'b0000, hour_loc[4:0], 2'b00})
              + {5'b00000, minute_q};
    level_up  = (day_q >= night_q);
    level_gap = level_up ? day_q - night_q : night_q - day_q;
  end

  // Target selection. The ramp minute count is minutes into dawn, or minutes
  // left of dusk, so both ramps grow from the night level toward day.
  always_comb begin
    goal_direct = day_q;
    need_ramp   = 1'b0;
    k_full      = local_min - DAWN_START;
    case (mode_q)
      MODE_DAY:   goal_direct = day_q;
      MODE_NIGHT: goal_direct = night_q;
      default: begin
        if (!fresh) begin
          goal_direct = day_q;
        end else if (local_min < DAWN_START || local_min >= DUSK_END) begin
          goal_direct = night_q;
        end else if (local_min >= DAY_START && local_min < DAY_END) begin
          goal_direct = day_q;
        end else begin
          need_ramp = 1'b1;
          if (local_min >= DAY_START) begin
            k_full = DUSK_END - local_min;
          end
        end
      end
    endcase
  end

  // The ramp offset is isqrt(gap*gap*k / 120). Going down from night toward
  // a darker day, the offset rounds up unless the division and root are exact.
  always_comb begin
    if (up_q) begin
      ramp_goal = night_q + sqrt_root;
    end else begin
      ramp_goal = night_q - sqrt_root - {7'b0000000, !(sqrt_exact && divrem_zero_q)};
    end
  end

  // Fade step size: min(elapsed, fade) * 255 / fade, at least one. The scaled
  // span is below 256 times the fade time, so the upper bits preload the
  // divider and only eight quotient bits remain.
  always_comb begin
    fade_eff  = (fade_q == '0) ? 16'd1 : fade_q;
    span      = (elapsed_q < {16'h0000, fade_eff}) ? elapsed_q[FADE_W-1:0] : fade_eff;
    scaled    = {span, 8'h00} - {8'h00, span};
    want_step = (cur_q != goal_q) && (elapsed_q >= STEP_PERIOD_MS);
    step_amt  = (div_quo[DUTY_W-1:0] == '0) ? 8'd1 : div_quo[DUTY_W-1:0];
    if (cur_q < goal_q) begin
      gap       = goal_q - cur_q;
      next_duty = (gap <= step_amt) ? goal_q : cur_q + step_amt;
    end else begin
      gap       = cur_q - goal_q;
      next_duty = (gap <= step_amt) ? goal_q : cur_q - step_amt;
    end
  end

  // Sequencer and operand selection for the shared units.
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    mul_mcand  = {8'h00, level_gap};
    mul_mplier = level_gap;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    if (state_q == S_STEP) begin
      div_rem_init = scaled[FADE_W+DUTY_W-1:DUTY_W];
      div_low      = {scaled[DUTY_W-1:0], 8'h00};
      div_divisor  = fade_eff;
      div_iters    = DIV_ITERS_STEP;
    end else begin
      div_rem_init = {8'h00, mul_prod[DIV_W+MUL_W-1:DIV_W]};
      div_low      = mul_prod[DIV_W-1:0];
      div_divisor  = RAMP_MINUTES;
      div_iters    = DIV_ITERS_RAMP;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        if (need_ramp) begin
          mul_start = 1'b1;
          state_d   = S_MUL1;
        end else begin
          state_d = S_STEP;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = mul_prod[DIV_W-1:0];
          mul_mplier = {1'b0, k_q};
          state_d    = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) state_d = S_STEP;
      end
      S_STEP: begin
        if (want_step) begin
          div_start = 1'b1;
          state_d   = S_DIV2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV2: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      day_q       <= DAY_LEVEL_RST;
      night_q     <= NIGHT_LEVEL_RST;
      fade_q      <= FADE_TIME_RST;
      cur_q       <= DUTY_RST;
      goal_q      <= DUTY_RST;
      last_q      <= '0;
      step_flag_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // A write to an index past the register list is dropped.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DAY_LEVEL:   day_q   <= cfg_data_i[DUTY_W-1:0];
          CFG_NIGHT_LEVEL: night_q <= cfg_data_i[DUTY_W-1:0];
          CFG_FADE_TIME:   fade_q  <= cfg_data_i;
          default:         ;
        endcase
      end

      if (state_q == S_PREP && !need_ramp) goal_q <= goal_direct;
      if (state_q == S_SQRT && sqrt_done) goal_q <= ramp_goal;

      if (state_q == S_STEP) begin
        step_flag_q <= 1'b0;
        // At the target the step timer keeps restarting.
        if (cur_q == goal_q) last_q <= now_q;
      end

      if (state_q == S_DIV2 && div_done) begin
        cur_q       <= next_duty;
        last_q      <= now_q;
        step_flag_q <= 1'b1;
      end

      // The output register frees the input side while a result waits.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      now_q    <= now_ms_i;
      mode_q   <= operation_i;
      cvalid_q <= clock_valid_i;
      stamp_q  <= clock_stamp_ms_i;
      hour_q   <= utc_hour_i;
      minute_q <= utc_minute_i;
    end
    if (state_q == S_PREP) begin
      elapsed_q <= now_q - last_q;
      k_q       <= k_full[RAMP_W-1:0];
      up_q      <= level_up;
    end
    if (state_q == S_DIV1 && div_done) begin
      divrem_zero_q <= (div_rem == '0);
    end
    if (state_q == S_DONE && out_free) begin
      out_duty_q    <= cur_q;
      out_target_q  <= goal_q;
      out_stepped_q <= step_flag_q;
    end
  end

  bdf_serial_mult u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .prod_o   (mul_prod),
    .done_o   (mul_done)
  );

  bdf_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .low_i      (div_low),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  bdf_serial_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quo),
    .root_o     (sqrt_root),
    .exact_o    (sqrt_exact),
    .done_o     (sqrt_done)
  );

  assign out_valid_o    = out_valid_q;
  assign duty_o         = out_duty_q;
  assign target_duty_o  = out_target_q;
  assign duty_stepped_o = out_stepped_q;

`ifndef SYNTHESIS
  // A result only appears when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the hand-over step");

  // A completed fade step always moves the duty.
  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV2 && div_done) |=> (cur_q != $past(cur_q)))
    else $error("fade step left the duty unchanged");

  // At the target no step division is started.
  a_no_step_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && cur_q == goal_q) |=> (state_q == S_DONE))
    else $error("step started although duty is at the target");
`endif

endmodule
